>>> hdl/tit_pkg.sv
`timescale 1ns / 1ps

package tit_pkg;

   localparam int CORNERS     = 4;
   localparam int AXES        = 3;
   localparam int ISO_BITS    = 16;
   localparam int RSP_ID_BITS = 32;

   typedef logic signed [ISO_BITS-1:0] iso_type;
   typedef logic [RSP_ID_BITS-1:0]     rsp_id_type;

   // fan: one triangle around a lone corner, pair: two triangles from the split table
   typedef enum logic {
      KIND_FAN,
      KIND_PAIR
   } kind_type;

   // corner order for the determinant and for the triangle edges
   typedef struct packed {
      kind_type   kind;
      logic [1:0] idx_a;
      logic [1:0] idx_b;
      logic [1:0] idx_g;
      logic [1:0] idx_d;
   } job_ctl_type;

   function automatic job_ctl_type classify(input logic [CORNERS-1:0] mask);
      logic [2:0]  ones;
      logic [1:0]  lone;
      logic        pick_set;
      job_ctl_type ctl;
      ones = {2'b00, mask[0]} + {2'b00, mask[1]} + {2'b00, mask[2]} + {2'b00, mask[3]};
      pick_set = (ones == 3'd1);
      lone = 2'd0;
      for (int j = 0; j < CORNERS; j++) begin
         if (mask[j] == pick_set) begin
            lone = 2'(j);
         end
      end
      // fan: lone corner last, the other three ascending
      ctl.kind  = KIND_FAN;
      ctl.idx_d = lone;
      ctl.idx_a = (lone == 2'd0) ? 2'd1 : 2'd0;
      ctl.idx_b = (lone <= 2'd1) ? 2'd2 : 2'd1;
      ctl.idx_g = (lone <= 2'd2) ? 2'd3 : 2'd2;
      if (ones == 3'd2) begin
         ctl.kind = KIND_PAIR;
         case (mask)
            4'd3:    {ctl.idx_a, ctl.idx_b, ctl.idx_g, ctl.idx_d} = 8'b00_01_11_10;
            4'd5:    {ctl.idx_a, ctl.idx_b, ctl.idx_g, ctl.idx_d} = 8'b00_10_11_01;
            4'd6:    {ctl.idx_a, ctl.idx_b, ctl.idx_g, ctl.idx_d} = 8'b01_10_11_00;
            4'd9:    {ctl.idx_a, ctl.idx_b, ctl.idx_g, ctl.idx_d} = 8'b00_11_10_01;
            4'd10:   {ctl.idx_a, ctl.idx_b, ctl.idx_g, ctl.idx_d} = 8'b01_11_10_00;
            4'd12:   {ctl.idx_a, ctl.idx_b, ctl.idx_g, ctl.idx_d} = 8'b10_11_01_00;
            default: {ctl.idx_a, ctl.idx_b, ctl.idx_g, ctl.idx_d} = 8'b00_01_10_11;
         endcase
      end
      return ctl;
   endfunction

endpackage

>>> hdl/tit_queue.sv
`timescale 1ns / 1ps

module tit_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'(DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign pop_data = data_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/tit_front.sv
`timescale 1ns / 1ps

module tit_front import tit_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int ID_BITS    = 32,
   parameter int JOB_BITS   = CORNERS * (AXES * COORD_BITS + ID_BITS) + $bits(job_ctl_type)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  iso_type                      req_sample_value,
   input  logic [ID_BITS-1:0]           req_corner_id,
   input  logic                         csr_write_enable,
   input  iso_type                      csr_write_data,
   output logic                         job_push,
   output logic [JOB_BITS-1:0]          job_data,
   input  logic                         job_full
);

   localparam int KEPT = CORNERS - 1;
   localparam int POS_BITS = CORNERS * AXES * COORD_BITS;

   iso_type                      iso_ff, iso_in;
   logic [1:0]                   count_ff, count_in;
   logic [KEPT-1:0]              flags_ff, flags_in;
   logic signed [COORD_BITS-1:0] pos_ff [KEPT][AXES];
   logic [ID_BITS-1:0]           id_ff [KEPT];
   logic signed [COORD_BITS-1:0] cur_pos [AXES];
   logic                         accept, above_iso, last_corner;
   logic [CORNERS-1:0]           mask;

   assign cur_pos[0] = req_pos_x;
   assign cur_pos[1] = req_pos_y;
   assign cur_pos[2] = req_pos_z;

   assign last_corner = (count_ff == 2'(KEPT));
   assign req_full    = last_corner && job_full;
   assign accept      = req_push && !req_full;
   assign above_iso   = (req_sample_value > iso_ff);
   assign mask        = {above_iso, flags_ff};
   // all inside or all outside gives no surface
   assign job_push    = accept && last_corner && (mask != '0) && (mask != '1);

   always_comb begin
      job_data = '0;
      for (int c = 0; c < KEPT; c++) begin
         for (int ax = 0; ax < AXES; ax++) begin
            job_data[(c * AXES + ax) * COORD_BITS +: COORD_BITS] = pos_ff[c][ax];
         end
         job_data[POS_BITS + c * ID_BITS +: ID_BITS] = id_ff[c];
      end
      for (int ax = 0; ax < AXES; ax++) begin
         job_data[(KEPT * AXES + ax) * COORD_BITS +: COORD_BITS] = cur_pos[ax];
      end
      job_data[POS_BITS + KEPT * ID_BITS +: ID_BITS] = req_corner_id;
      job_data[JOB_BITS-1 -: $bits(job_ctl_type)] = classify(mask);
   end

   always_comb begin
      iso_in   = csr_write_enable ? csr_write_data : iso_ff;
      count_in = count_ff;
      flags_in = flags_ff;
      if (accept) begin
         count_in = last_corner ? 2'd0 : count_ff + 2'd1;
         if (!last_corner) begin
            flags_in[count_ff] = above_iso;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff   <= '0;
         count_ff <= 2'd0;
         flags_ff <= '0;
      end else begin
         iso_ff   <= iso_in;
         count_ff <= count_in;
         flags_ff <= flags_in;
      end
      if (accept && !last_corner) begin
         for (int ax = 0; ax < AXES; ax++) begin
            pos_ff[count_ff][ax] <= cur_pos[ax];
         end
         id_ff[count_ff] <= req_corner_id;
      end
   end

endmodule

>>> hdl/tit_back.sv
`timescale 1ns / 1ps

module tit_back import tit_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int ID_BITS    = 32,
   parameter int JOB_BITS   = CORNERS * (AXES * COORD_BITS + ID_BITS) + $bits(job_ctl_type)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [JOB_BITS-1:0] job_data,
   input  logic                job_empty,
   output logic                job_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_id_type          rsp_c0_end_a,
   output rsp_id_type          rsp_c0_end_b,
   output rsp_id_type          rsp_c1_end_a,
   output rsp_id_type          rsp_c1_end_b,
   output rsp_id_type          rsp_c2_end_a,
   output rsp_id_type          rsp_c2_end_b,
   output logic                rsp_last_triangle
);

   localparam int POS_BITS = CORNERS * AXES * COORD_BITS;
   localparam int DW   = COORD_BITS + 1;     // edge vector component
   localparam int PW   = 2 * DW;             // 2x2 minor product
   localparam int MW   = 2 * DW + 1;         // minor
   localparam int LOW  = DW;                 // low slice of a minor
   localparam int HW   = MW - LOW;           // high slice of a minor
   localparam int SW   = 2 * DW + 1;         // partial product of a cofactor term
   localparam int TW   = 3 * DW + 1;         // cofactor term
   localparam int DETW = TW + 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_MINOR,
      ST_TERM,
      ST_COMBINE,
      ST_SUM,
      ST_DET,
      ST_EMIT_FIRST,
      ST_EMIT_SECOND
   } state_type;

   state_type                    state_ff, state_in;
   logic                         out_valid_ff, out_valid_in;
   rsp_id_type                   end_ff [3][2];
   rsp_id_type                   end_in [3][2];
   logic                         last_ff, last_in;
   job_ctl_type                  ctl_ff, ctl_in;
   logic [ID_BITS-1:0]           id_ff [CORNERS];
   logic [ID_BITS-1:0]           id_in [CORNERS];

   logic signed [DW-1:0]         diff_ff [3][AXES];
   logic signed [DW-1:0]         diff_in [3][AXES];
   logic signed [PW-1:0]         pp_ff [AXES][2];
   logic signed [PW-1:0]         pp_in [AXES][2];
   logic signed [MW-1:0]         minor_ff [AXES];
   logic signed [MW-1:0]         minor_in [AXES];
   logic signed [SW-1:0]         plo_ff [AXES];
   logic signed [SW-1:0]         plo_in [AXES];
   logic signed [SW-1:0]         phi_ff [AXES];
   logic signed [SW-1:0]         phi_in [AXES];
   logic signed [TW-1:0]         term_ff [AXES];
   logic signed [TW-1:0]         term_in [AXES];
   logic signed [DETW-1:0]       sum_ff, sum_in;
   logic signed [DETW-1:0]       det_ff, det_in;

   job_ctl_type                  job_ctl;
   logic signed [COORD_BITS-1:0] job_pos [CORNERS][AXES];
   logic [ID_BITS-1:0]           job_id [CORNERS];
   logic                         swap, second, emitting, slot_free, out_load;
   logic [1:0]                   edge_idx [3][2];
   logic [1:0]                   pick [3][2];

   // unpack the job at the queue head
   always_comb begin
      for (int c = 0; c < CORNERS; c++) begin
         for (int ax = 0; ax < AXES; ax++) begin
            job_pos[c][ax] = job_data[(c * AXES + ax) * COORD_BITS +: COORD_BITS];
         end
         job_id[c] = job_data[POS_BITS + c * ID_BITS +: ID_BITS];
      end
      job_ctl = job_data[JOB_BITS-1 -: $bits(job_ctl_type)];
   end

   assign job_pop   = (state_ff == ST_IDLE) && !job_empty;
   assign rsp_empty = !out_valid_ff;

   // determinant datapath, rows b-a, g-b, d-g, expanded along the first row
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int ax = 0; ax < AXES; ax++) begin
            diff_in[r][ax] = diff_ff[r][ax];
         end
      end
      if (job_pop) begin
         for (int ax = 0; ax < AXES; ax++) begin
            diff_in[0][ax] = DW'(job_pos[job_ctl.idx_b][ax]) - DW'(job_pos[job_ctl.idx_a][ax]);
            diff_in[1][ax] = DW'(job_pos[job_ctl.idx_g][ax]) - DW'(job_pos[job_ctl.idx_b][ax]);
            diff_in[2][ax] = DW'(job_pos[job_ctl.idx_d][ax]) - DW'(job_pos[job_ctl.idx_g][ax]);
         end
      end
      pp_in[0][0] = diff_ff[1][1] * diff_ff[2][2];
      pp_in[0][1] = diff_ff[1][2] * diff_ff[2][1];
      pp_in[1][0] = diff_ff[1][2] * diff_ff[2][0];
      pp_in[1][1] = diff_ff[1][0] * diff_ff[2][2];
      pp_in[2][0] = diff_ff[1][0] * diff_ff[2][1];
      pp_in[2][1] = diff_ff[1][1] * diff_ff[2][0];
      for (int k = 0; k < AXES; k++) begin
         minor_in[k] = MW'(pp_ff[k][0]) - MW'(pp_ff[k][1]);
         // minor split in two slices to keep each multiplier narrow
         plo_in[k]   = diff_ff[0][k] * $signed({1'b0, minor_ff[k][LOW-1:0]});
         phi_in[k]   = diff_ff[0][k] * $signed(minor_ff[k][MW-1:LOW]);
         term_in[k]  = (TW'(phi_ff[k]) <<< LOW) + TW'(plo_ff[k]);
      end
      sum_in = DETW'(term_ff[0]) + DETW'(term_ff[1]);
      det_in = sum_ff + DETW'(term_ff[2]);
   end

   // triangle edges as corner index pairs
   assign swap      = det_ff[DETW-1] || (det_ff == '0);
   assign second    = (state_ff == ST_EMIT_SECOND);
   assign emitting  = (state_ff == ST_EMIT_FIRST) || second;
   assign slot_free = !out_valid_ff || rsp_pop;
   assign out_load  = emitting && slot_free;

   always_comb begin
      if (ctl_ff.kind == KIND_FAN) begin
         edge_idx[0][0] = ctl_ff.idx_d;  edge_idx[0][1] = ctl_ff.idx_a;
         edge_idx[1][0] = ctl_ff.idx_d;  edge_idx[1][1] = ctl_ff.idx_b;
         edge_idx[2][0] = ctl_ff.idx_d;  edge_idx[2][1] = ctl_ff.idx_g;
      end else if (!second) begin
         edge_idx[0][0] = ctl_ff.idx_a;  edge_idx[0][1] = ctl_ff.idx_g;
         edge_idx[1][0] = ctl_ff.idx_g;  edge_idx[1][1] = ctl_ff.idx_b;
         edge_idx[2][0] = ctl_ff.idx_b;  edge_idx[2][1] = ctl_ff.idx_d;
      end else begin
         edge_idx[0][0] = ctl_ff.idx_a;  edge_idx[0][1] = ctl_ff.idx_g;
         edge_idx[1][0] = ctl_ff.idx_b;  edge_idx[1][1] = ctl_ff.idx_d;
         edge_idx[2][0] = ctl_ff.idx_a;  edge_idx[2][1] = ctl_ff.idx_d;
      end
      for (int e = 0; e < 2; e++) begin
         pick[0][e] = edge_idx[0][e];
         pick[1][e] = swap ? edge_idx[2][e] : edge_idx[1][e];
         pick[2][e] = swap ? edge_idx[1][e] : edge_idx[2][e];
      end
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
      ctl_in       = job_pop ? job_ctl : ctl_ff;
      for (int c = 0; c < CORNERS; c++) begin
         id_in[c] = job_pop ? job_id[c] : id_ff[c];
      end
      last_in = out_load ? ((ctl_ff.kind == KIND_FAN) || second) : last_ff;
      for (int t = 0; t < 3; t++) begin
         for (int e = 0; e < 2; e++) begin
            end_in[t][e] = out_load ? rsp_id_type'(id_ff[pick[t][e]]) : end_ff[t][e];
         end
      end
      case (state_ff)
         ST_IDLE:        if (job_pop) state_in = ST_PROD;
         ST_PROD:        state_in = ST_MINOR;
         ST_MINOR:       state_in = ST_TERM;
         ST_TERM:        state_in = ST_COMBINE;
         ST_COMBINE:     state_in = ST_SUM;
         ST_SUM:         state_in = ST_DET;
         ST_DET:         state_in = ST_EMIT_FIRST;
         ST_EMIT_FIRST: begin
            if (slot_free) begin
               state_in = (ctl_ff.kind == KIND_PAIR) ? ST_EMIT_SECOND : ST_IDLE;
            end
         end
         ST_EMIT_SECOND: if (slot_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      last_ff <= last_in;
      for (int t = 0; t < 3; t++) begin
         for (int e = 0; e < 2; e++) begin
            end_ff[t][e] <= end_in[t][e];
         end
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in;
      for (int c = 0; c < CORNERS; c++) begin
         id_ff[c] <= id_in[c];
      end
      for (int r = 0; r < 3; r++) begin
         for (int ax = 0; ax < AXES; ax++) begin
            diff_ff[r][ax] <= diff_in[r][ax];
         end
      end
      for (int k = 0; k < AXES; k++) begin
         pp_ff[k][0] <= pp_in[k][0];
         pp_ff[k][1] <= pp_in[k][1];
         minor_ff[k] <= minor_in[k];
         plo_ff[k]   <= plo_in[k];
         phi_ff[k]   <= phi_in[k];
         term_ff[k]  <= term_in[k];
      end
      sum_ff <= sum_in;
      det_ff <= det_in;
   end

   assign rsp_c0_end_a      = end_ff[0][0];
   assign rsp_c0_end_b      = end_ff[0][1];
   assign rsp_c1_end_a      = end_ff[1][0];
   assign rsp_c1_end_b      = end_ff[1][1];
   assign rsp_c2_end_a      = end_ff[2][0];
   assign rsp_c2_end_b      = end_ff[2][1];
   assign rsp_last_triangle = last_ff;

endmodule

>>> hdl/tetra_isosurface_triangulator.sv
`timescale 1ns / 1ps

// marching tetrahedra triangulator
// - req_ side: one corner word per push (position, sample, id); four words make one
//   tetrahedron. a corner is inside when its sample is above the isovalue, tested as it
//   arrives. corner words are taken one per cycle; req_full only rises on a fourth corner
//   while the two-entry job queue is full
// - rsp_ side: one triangle per word, each triangle corner given as the two corner ids of
//   the crossing edge; rsp_last_triangle marks the final triangle of a tetrahedron.
//   no, one or two triangles per tetrahedron
// - csr_ side: isovalue, written while idle
// - fourth corner to first triangle on rsp_ runs through the determinant sequence
//   (diff, 2x2 minors, split cofactor products, two wide adds)
// - the back end takes one tetrahedron at a time: the determinant states, then an emit
//   state for each triangle; the front keeps collecting meanwhile
// - reset clears the corner count, the isovalue, the job queue and the result register
// - a stalled rsp_pop holds the result; the back end then waits and the queue fills,
//   after which req_full stops only the fourth corner of the next tetrahedron

module tetra_isosurface_triangulator import tit_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int ID_BITS    = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // corner words
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  iso_type                      req_sample_value,
   input  logic [ID_BITS-1:0]           req_corner_id,
   // triangle words
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output rsp_id_type                   rsp_c0_end_a,
   output rsp_id_type                   rsp_c0_end_b,
   output rsp_id_type                   rsp_c1_end_a,
   output rsp_id_type                   rsp_c1_end_b,
   output rsp_id_type                   rsp_c2_end_a,
   output rsp_id_type                   rsp_c2_end_b,
   output logic                         rsp_last_triangle,
   // isovalue register
   input  logic                         csr_write_enable,
   input  iso_type                      csr_write_data
);

   // one job: four corners, four ids and the classification
   localparam int JOB_BITS = CORNERS * (AXES * COORD_BITS + ID_BITS) + $bits(job_ctl_type);

   logic                job_push, job_full, job_pop, job_empty;
   logic [JOB_BITS-1:0] job_in_data, job_out_data;

   // collects corners, tests inside and classifies on the fourth corner
   tit_front #(
      .COORD_BITS (COORD_BITS),
      .ID_BITS    (ID_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_sample_value (req_sample_value),
      .req_corner_id    (req_corner_id),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .job_push         (job_push),
      .job_data         (job_in_data),
      .job_full         (job_full)
   );

   // decouples classification from the determinant and emit sequence
   tit_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   // winding from the determinant sign, then one or two triangle words
   tit_back #(
      .COORD_BITS (COORD_BITS),
      .ID_BITS    (ID_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_data          (job_out_data),
      .job_empty         (job_empty),
      .job_pop           (job_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_c0_end_a      (rsp_c0_end_a),
      .rsp_c0_end_b      (rsp_c0_end_b),
      .rsp_c1_end_a      (rsp_c1_end_a),
      .rsp_c1_end_b      (rsp_c1_end_b),
      .rsp_c2_end_a      (rsp_c2_end_a),
      .rsp_c2_end_b      (rsp_c2_end_b),
      .rsp_last_triangle (rsp_last_triangle)
   );

endmodule

>>> tb/tetra_isosurface_triangulator_test.sv
`timescale 1ns / 1ps

module tetra_isosurface_triangulator_test;
   import tit_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   // settle time covers the latency to first triangle and two queued jobs
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      rsp_id_type c0a;
      rsp_id_type c0b;
      rsp_id_type c1a;
      rsp_id_type c1b;
      rsp_id_type c2a;
      rsp_id_type c2b;
      logic       last;
   } triangle_type;

   typedef enum {
      SHAPE_RANDOM,
      SHAPE_UNIT,
      SHAPE_MIRROR,
      SHAPE_EXTREME,
      SHAPE_FLAT,
      SHAPE_SMALL
   } shape_type;

   // expected triangles for the corner words seen so far
   class triangle_scoreboard;
      int           errors;
      iso_type      iso;
      longint       px[4];
      longint       py[4];
      longint       pz[4];
      rsp_id_type   ids[4];
      logic [3:0]   inside_mask;
      int           fill;
      rsp_id_type   tri_ends[6];
      triangle_type pending_tris[$];

      function new();
         errors      = 0;
         iso         = '0;
         inside_mask = '0;
         fill        = 0;
      endfunction

      function void set_iso(iso_type v);
         iso = v;
      endfunction

      function int pending_count();
         return pending_tris.size();
      endfunction

      // det(b-a, c-b, d-c) <= 0 swaps corners one and two
      function bit det_nonpositive(int p0, int p1, int p2, int p3);
         longint ux, uy, uz, vx, vy, vz, wx, wy, wz, det;
         ux  = px[p1] - px[p0];
         uy  = py[p1] - py[p0];
         uz  = pz[p1] - pz[p0];
         vx  = px[p2] - px[p1];
         vy  = py[p2] - py[p1];
         vz  = pz[p2] - pz[p1];
         wx  = px[p3] - px[p2];
         wy  = py[p3] - py[p2];
         wz  = pz[p3] - pz[p2];
         det = ux * (vy * wz - vz * wy) - uy * (vx * wz - vz * wx) + uz * (vx * wy - vy * wx);
         return det <= 0;
      endfunction

      function void place(int pos, int ea, int eb);
         tri_ends[2*pos]   = ids[ea];
         tri_ends[2*pos+1] = ids[eb];
      endfunction

      function void emit(bit last);
         triangle_type t;
         t.c0a  = tri_ends[0];
         t.c0b  = tri_ends[1];
         t.c1a  = tri_ends[2];
         t.c1b  = tri_ends[3];
         t.c2a  = tri_ends[4];
         t.c2b  = tri_ends[5];
         t.last = last;
         pending_tris.push_back(t);
      endfunction

      function void note_corner(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z, iso_type s, rsp_id_type id);
         int k, ones, lone, a, b, g, d, p;
         bit sw;
         k              = fill;
         px[k]          = x;
         py[k]          = y;
         pz[k]          = z;
         ids[k]         = id;
         inside_mask[k] = (s > iso);
         if (k < 3) begin
            fill = k + 1;
            return;
         end
         fill = 0;
         ones = $countones(inside_mask);
         if (ones == 1 || ones == 3) begin
            lone = 0;
            for (int j = 0; j < 4; j++) begin
               if (inside_mask[j] == (ones == 1)) begin
                  lone = j;
               end
            end
            a  = (lone == 0) ? 1 : 0;
            b  = (lone <= 1) ? 2 : 1;
            g  = (lone <= 2) ? 3 : 2;
            sw = det_nonpositive(a, b, g, lone);
            place(0, lone, a);
            place(1 + sw, lone, b);
            place(2 - sw, lone, g);
            emit(1'b1);
         end else if (ones == 2) begin
            p  = int'(inside_mask);
            a  = (p / 6) - ((p == 9) ? 1 : 0);
            b  = 1 + ((p > 3) ? 1 : 0) + ((p > 6) ? 1 : 0);
            g  = 1 + ((p < 12) ? 1 : 0) + ((p < 9) ? 1 : 0);
            d  = 6 - (a + b + g);
            sw = det_nonpositive(a, b, g, d);
            place(0, a, g);
            place(1 + sw, g, b);
            place(2 - sw, b, d);
            emit(1'b0);
            place(0, a, g);
            place(1 + sw, b, d);
            place(2 - sw, a, d);
            emit(1'b1);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_triangle(triangle_type got);
         triangle_type want;
         if (pending_tris.size() == 0) begin
            $error("unexpected triangle word: %h", got);
            errors++;
            return;
         end
         want = pending_tris.pop_front();
         compare_field("c0_end_a", want.c0a, got.c0a);
         compare_field("c0_end_b", want.c0b, got.c0b);
         compare_field("c1_end_a", want.c1a, got.c1a);
         compare_field("c1_end_b", want.c1b, got.c1b);
         compare_field("c2_end_a", want.c2a, got.c2a);
         compare_field("c2_end_b", want.c2b, got.c2b);
         compare_field("last_triangle", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   // dut signals, all inputs known from time zero
   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_push          = 1'b0;
   logic                req_full;
   logic signed [15:0]  req_pos_x         = '0;
   logic signed [15:0]  req_pos_y         = '0;
   logic signed [15:0]  req_pos_z         = '0;
   iso_type             req_sample_value  = '0;
   logic [31:0]         req_corner_id     = '0;
   logic                rsp_empty;
   logic                rsp_pop           = 1'b0;
   rsp_id_type          rsp_c0_end_a;
   rsp_id_type          rsp_c0_end_b;
   rsp_id_type          rsp_c1_end_a;
   rsp_id_type          rsp_c1_end_b;
   rsp_id_type          rsp_c2_end_a;
   rsp_id_type          rsp_c2_end_b;
   logic                rsp_last_triangle;
   logic                csr_write_enable  = 1'b0;
   iso_type             csr_write_data    = '0;

   triangle_scoreboard  sb = new();

   // stimulus controls shared by the two sides
   iso_type             cur_iso      = '0;
   bit                  idling_on    = 1'b0;
   int                  rsp_hold_req = 0;
   int                  cycle_count  = 0;

   tetra_isosurface_triangulator #(
      .COORD_BITS (16),
      .ID_BITS    (32)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_sample_value  (req_sample_value),
      .req_corner_id     (req_corner_id),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_c0_end_a      (rsp_c0_end_a),
      .rsp_c0_end_b      (rsp_c0_end_b),
      .rsp_c1_end_a      (rsp_c1_end_a),
      .rsp_c1_end_b      (rsp_c1_end_b),
      .rsp_c2_end_a      (rsp_c2_end_a),
      .rsp_c2_end_b      (rsp_c2_end_b),
      .rsp_last_triangle (rsp_last_triangle),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // 8 ns clock
   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // idle gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(50, 10);
   endfunction

   // sample on the requested side of the isovalue, with boundary and extreme values
   function automatic iso_type pick_sample(bit above, bit noise);
      int lo, hi, r;
      if (noise) return iso_type'($urandom);
      if (above && cur_iso != 16'sh7fff) begin
         lo = int'(cur_iso) + 1;
         hi = 32767;
      end else begin
         above = 1'b0;
         lo = -32768;
         hi = int'(cur_iso);
      end
      r = $urandom_range(3);
      case (r)
         0:       return iso_type'(above ? lo : hi);
         1:       return iso_type'(above ? hi : lo);
         default: return iso_type'(lo + int'($urandom_range(hi - lo)));
      endcase
   endfunction

   // one corner word: gap, drive at falling edge, wait for the accepting rising edge
   task automatic send_corner(input int k, input bit above, input shape_type shape,
                              input bit noise);
      int                 g;
      logic signed [15:0] x, y, z;
      iso_type            s;
      logic [31:0]        id;
      id = $urandom;
      case (shape)
         SHAPE_UNIT: begin
            x = (k == 1) ? 16'sd1 : 16'sd0;
            y = (k == 2) ? 16'sd1 : 16'sd0;
            z = (k == 3) ? 16'sd1 : 16'sd0;
         end
         SHAPE_MIRROR: begin
            x = (k == 1) ? -16'sd1 : 16'sd0;
            y = (k == 2) ? -16'sd1 : 16'sd0;
            z = (k == 3) ? -16'sd1 : 16'sd0;
         end
         SHAPE_EXTREME: begin
            // full-range coordinates and the extreme ids
            x  = (k == 1) ? 16'sh7fff : 16'sh8000;
            y  = (k == 2) ? 16'sh7fff : 16'sh8000;
            z  = (k == 3) ? 16'sh7fff : 16'sh8000;
            id = k[0] ? 32'hffff_ffff : 32'h0000_0000;
         end
         SHAPE_FLAT: begin
            // all four corners in one plane, determinant zero
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'sd100;
         end
         SHAPE_SMALL: begin
            x = 16'(int'($urandom_range(15)) - 8);
            y = 16'(int'($urandom_range(15)) - 8);
            z = 16'(int'($urandom_range(15)) - 8);
         end
         default: begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
         end
      endcase
      s = pick_sample(above, noise);
      g = idling_on ? pick_gap() : 0;
      if (g > 0) begin
         req_push <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_pos_x        <= x;
      req_pos_y        <= y;
      req_pos_z        <= z;
      req_sample_value <= s;
      req_corner_id    <= id;
      req_push         <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note_corner(x, y, z, s, id);
      @(negedge clock);
   endtask

   task automatic send_tetra(input logic [3:0] mask, input shape_type shape, input bit noise);
      for (int k = 0; k < 4; k++) begin
         send_corner(k, mask[k], shape, noise);
      end
   endtask

   task automatic send_random_tetra();
      int        r;
      shape_type shape;
      r = $urandom_range(9);
      case (r)
         6:       shape = SHAPE_SMALL;
         7:       shape = SHAPE_FLAT;
         8:       shape = SHAPE_EXTREME;
         9:       shape = r[0] ? SHAPE_UNIT : SHAPE_MIRROR;
         default: shape = SHAPE_RANDOM;
      endcase
      // one in ten tetrahedra carries samples with no shaping at all
      send_tetra(4'($urandom_range(15)), shape, $urandom_range(9) == 0);
   endtask

   // isovalue write: sender pauses, every triangle drains, the back end settles
   task automatic write_iso(input iso_type v);
      req_push <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_iso(v);
      cur_iso = v;
   endtask

   // triangle side: pop decided at the falling edge, word taken at the rising edge
   initial begin
      int           gap_left;
      int           hold_left;
      triangle_type got;
      gap_left  = 0;
      hold_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            hold_left    = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            gap_left = idling_on ? pick_gap() : 0;
         end
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            got.c0a  = rsp_c0_end_a;
            got.c0b  = rsp_c0_end_b;
            got.c1a  = rsp_c1_end_a;
            got.c1b  = rsp_c1_end_b;
            got.c2a  = rsp_c2_end_a;
            got.c2b  = rsp_c2_end_b;
            got.last = rsp_last_triangle;
            sb.check_triangle(got);
         end
      end
   end

   // main sequence
   initial begin
      iso_type iso_list[8];
      iso_list = '{16'sh8000, 16'sh7fff, -16'sd1, 16'sd1, 16'sd0,
                   iso_type'($urandom), iso_type'($urandom), iso_type'($urandom)};

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: isovalue at its reset value, no idling
      write_iso(16'sd0);
      send_tetra(4'b0000, SHAPE_UNIT, 1'b0);     // nothing inside
      send_tetra(4'b1111, SHAPE_MIRROR, 1'b0);   // all inside
      send_tetra(4'b0001, SHAPE_UNIT, 1'b0);     // one inside
      send_tetra(4'b0111, SHAPE_MIRROR, 1'b0);   // three inside
      send_tetra(4'b0101, SHAPE_EXTREME, 1'b0);  // two inside, full-range coordinates
      send_tetra(4'b1100, SHAPE_FLAT, 1'b0);     // two inside, flat tetrahedron

      // isovalue changed with half a tetrahedron collected
      idling_on = 1'b1;
      send_corner(0, 1'b1, SHAPE_RANDOM, 1'b0);
      send_corner(1, 1'b0, SHAPE_RANDOM, 1'b0);
      write_iso(16'sh8000);
      send_corner(2, 1'b1, SHAPE_RANDOM, 1'b0);
      send_corner(3, 1'b0, SHAPE_RANDOM, 1'b0);

      // random phases, extremes of the isovalue among them
      for (int ph = 0; ph < 8; ph++) begin
         write_iso(iso_list[ph]);
         idling_on = (ph % 3) != 0;
         for (int t = 0; t < 15; t++) begin
            send_random_tetra();
         end
      end

      // backpressure: triangle side holds off while corners keep coming
      write_iso(iso_type'($urandom_range(200)) - 16'sd100);
      idling_on    = 1'b0;
      rsp_hold_req = HOLD_CYCLES;
      for (int t = 0; t < 12; t++) begin
         send_tetra(4'($urandom_range(15)), SHAPE_RANDOM, 1'b0);
      end
      idling_on = 1'b1;
      for (int t = 0; t < 8; t++) begin
         send_random_tetra();
      end

      // drain and settle
      req_push <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
